@@ hw/rtl/rvx_pkg.sv @@
// ============================================================================
// RV32I subset execute package
// Widths, opcodes, decoded operation types and pipeline records shared by the
// front end, the operation queue and the execution back end.
// ============================================================================
package rvx_pkg;

    localparam int XLEN        = 32;
    localparam int PC_W        = 30;
    localparam int REG_AW      = 5;
    localparam int REG_COUNT   = 32;
    localparam int DMEM_WORDS  = 256;
    localparam int DMEM_AW     = $clog2(DMEM_WORDS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_BRANCH = 7'h63;

    localparam logic [2:0] F3_ADD  = 3'h0;
    localparam logic [2:0] F3_XOR  = 3'h4;
    localparam logic [2:0] F3_OR   = 3'h6;
    localparam logic [2:0] F3_AND  = 3'h7;
    localparam logic [2:0] F3_WORD = 3'h2;
    localparam logic [2:0] F3_BEQ  = 3'h0;

    localparam logic [6:0] F7_ZERO = 7'h00;

    typedef enum logic [2:0] {
        K_ALU,
        K_LOAD,
        K_STORE,
        K_JAL,
        K_BEQ,
        K_BAD
    } t_kind;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_AND,
        ALU_OR,
        ALU_XOR
    } t_alu_op;

    typedef struct packed {
        t_kind              kind;
        t_alu_op            alu_op;
        logic               use_imm;
        logic [REG_AW-1:0]  rd;
        logic [REG_AW-1:0]  rs1;
        logic [REG_AW-1:0]  rs2;
        logic [XLEN-1:0]    imm;
    } t_uop;

    typedef struct packed {
        logic [PC_W-1:0]    next_pc;
        logic [REG_AW-1:0]  rd;
        logic               wr;
        logic               is_load;
        logic [XLEN-1:0]    value;
        logic               store;
        logic               status;
    } t_exec;

    typedef struct packed {
        logic [PC_W-1:0]    next_pc;
        logic [REG_AW-1:0]  rd;
        logic [XLEN-1:0]    value;
        logic               wr;
        logic               store;
        logic               status;
    } t_result;

endpackage

@@ hw/rtl/rvx_if.sv @@
// ============================================================================
// RV32I subset execute channels
// Valid/ready channels for instruction words in and execution results out.
// ============================================================================
interface rvx_in_if;
    logic                      valid;
    logic                      ready;
    logic [rvx_pkg::XLEN-1:0]  instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvx_out_if;
    logic                        valid;
    logic                        ready;
    logic [rvx_pkg::PC_W-1:0]    next_pc;
    logic [rvx_pkg::REG_AW-1:0]  dest_index;
    logic [rvx_pkg::XLEN-1:0]    dest_value;
    logic                        dest_write;
    logic                        store_done;
    logic                        status;

    modport source (output valid, output next_pc, output dest_index, output dest_value,
                    output dest_write, output store_done, output status, input ready);
    modport sink   (input valid, input next_pc, input dest_index, input dest_value,
                    input dest_write, input store_done, input status, output ready);
endinterface

@@ hw/rtl/rv32i_subset_execute.sv @@
// ============================================================================
// RV32I subset execute unit
// Executes ADD, AND, OR, XOR, their immediate forms, LW, SW, JAL and BEQ
// against a 32-entry register file, a word pc and a 256-word data memory.
// ============================================================================
// The unit sustains one instruction per cycle when the result side is not
// stalled: an instruction word can be transferred in every cycle, and one
// result is transferred out for each, in order, after it has passed the front
// decode register, the queue entry, operand read and execute with the data
// memory access, load data and register write, then the output register.
// The throughput is set by the execute stage with forwarding from the two
// newer register writes and by the one write and one read port of the data
// memory. Register file and data memory read as zero after reset through
// per-entry valid bits, so no clearing pass is needed and instructions are
// accepted right after reset. Unsupported encodings write nothing, leave
// the pc where it is and report status one.
module rv32i_subset_execute (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvx_in_if.sink    i_instr,
    rvx_out_if.source o_result
);

    logic          push_valid;
    rvx_pkg::t_uop push_uop;
    logic          push_ready;
    logic          head_valid;
    rvx_pkg::t_uop head_uop;
    logic          pop;

    rvx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr      (i_instr),
        .o_push_valid (push_valid),
        .o_push_uop   (push_uop),
        .i_push_ready (push_ready)
    );

    rvx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_uop   (push_uop),
        .o_push_ready (push_ready),
        .o_pop_valid  (head_valid),
        .o_pop_uop    (head_uop),
        .i_pop        (pop)
    );

    rvx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_uop),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

@@ hw/rtl/rvx_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ============================================================================
module rvx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rvx_front.sv @@
// ============================================================================
// RV32I subset front end
// Accepts instruction words, decodes and classifies them, and hands the
// decoded operations to the operation queue.
// ============================================================================
module rvx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rvx_in_if.sink        i_instr,
    output logic          o_push_valid,
    output rvx_pkg::t_uop o_push_uop,
    input  logic          i_push_ready
);

    logic                     r_valid;
    logic                     n_valid;
    rvx_pkg::t_uop            r_uop;
    rvx_pkg::t_uop            dec;
    logic [rvx_pkg::XLEN-1:0] word;
    logic [6:0]               opcode;
    logic [2:0]               funct3;
    logic [6:0]               funct7;
    logic                     alu_ok;
    rvx_pkg::t_alu_op         alu_op;
    logic                     take;

    assign word   = i_instr.instr_word;
    assign opcode = word[6:0];
    assign funct3 = word[14:12];
    assign funct7 = word[31:25];

    always_comb begin
        alu_ok = 1'b1;
        alu_op = rvx_pkg::ALU_ADD;
        unique case (funct3)
            rvx_pkg::F3_ADD: alu_op = rvx_pkg::ALU_ADD;
            rvx_pkg::F3_AND: alu_op = rvx_pkg::ALU_AND;
            rvx_pkg::F3_OR:  alu_op = rvx_pkg::ALU_OR;
            rvx_pkg::F3_XOR: alu_op = rvx_pkg::ALU_XOR;
            default:         alu_ok = 1'b0;
        endcase
    end

    always_comb begin
        dec         = '0;
        dec.kind    = rvx_pkg::K_BAD;
        dec.alu_op  = alu_op;
        dec.use_imm = 1'b0;
        dec.rd      = word[11:7];
        dec.rs1     = word[19:15];
        dec.rs2     = word[24:20];
        dec.imm     = {{20{word[31]}}, word[31:20]};
        unique case (opcode)
            rvx_pkg::OP_REG: begin
                if (funct7 == rvx_pkg::F7_ZERO && alu_ok) begin
                    dec.kind = rvx_pkg::K_ALU;
                end
            end
            rvx_pkg::OP_IMM: begin
                dec.use_imm = 1'b1;
                if (alu_ok) begin
                    dec.kind = rvx_pkg::K_ALU;
                end
            end
            rvx_pkg::OP_LOAD: begin
                if (funct3 == rvx_pkg::F3_WORD) begin
                    dec.kind = rvx_pkg::K_LOAD;
                end
            end
            rvx_pkg::OP_STORE: begin
                dec.imm = {{20{word[31]}}, word[31:25], word[11:7]};
                if (funct3 == rvx_pkg::F3_WORD) begin
                    dec.kind = rvx_pkg::K_STORE;
                end
            end
            rvx_pkg::OP_JAL: begin
                dec.imm  = {{11{word[31]}}, word[31], word[19:12], word[20],
                            word[30:21], 1'b0};
                dec.kind = rvx_pkg::K_JAL;
            end
            rvx_pkg::OP_BRANCH: begin
                dec.imm = {{19{word[31]}}, word[31], word[7], word[30:25],
                           word[11:8], 1'b0};
                if (funct3 == rvx_pkg::F3_BEQ) begin
                    dec.kind = rvx_pkg::K_BEQ;
                end
            end
            default: begin
                dec.kind = rvx_pkg::K_BAD;
            end
        endcase
    end

    assign i_instr.ready = !r_valid || i_push_ready;
    assign take          = i_instr.valid && i_instr.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_instr.ready) begin
            n_valid = i_instr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_uop <= dec;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_uop   = r_uop;

endmodule

@@ hw/rtl/rvx_queue.sv @@
// ============================================================================
// RV32I subset operation queue
// Short first-in first-out buffer of decoded operations between the front
// end and the execution back end.
// ============================================================================
module rvx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  rvx_pkg::t_uop i_push_uop,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output rvx_pkg::t_uop o_pop_uop,
    input  logic          i_pop
);

    rvx_pkg::t_uop                r_entries [rvx_pkg::QUEUE_DEPTH];
    logic [rvx_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [rvx_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [rvx_pkg::QUEUE_AW:0]   r_count;
    logic [rvx_pkg::QUEUE_AW:0]   n_count;
    logic                         push;
    logic                         pop;

    assign o_push_ready = r_count != (rvx_pkg::QUEUE_AW + 1)'(rvx_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_uop    = r_entries[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_count = r_count;
        unique case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= rvx_pkg::QUEUE_AW'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= rvx_pkg::QUEUE_AW'(r_rd_ptr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_wr_ptr] <= i_push_uop;
        end
    end

endmodule

@@ hw/rtl/rvx_back.sv @@
// ============================================================================
// RV32I subset execution back end
// Reads operands, executes, accesses data memory and writes the register
// file in a stalling three-stage pipeline with operand forwarding.
// ============================================================================
module rvx_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  rvx_pkg::t_uop i_head,
    output logic          o_pop,
    rvx_out_if.source     o_result
);

    logic                           advance;
    logic                           r_s1_valid;
    rvx_pkg::t_uop                  r_s1;
    logic                           r_s2_valid;
    rvx_pkg::t_exec                 r_s2;
    rvx_pkg::t_exec                 exec;
    logic                           r_out_valid;
    rvx_pkg::t_result               r_out;
    logic                           r_wb_valid;
    logic [rvx_pkg::REG_AW-1:0]     r_wb_rd;
    logic [rvx_pkg::XLEN-1:0]       r_wb_value;
    logic [rvx_pkg::PC_W-1:0]       r_pc;
    logic [rvx_pkg::REG_COUNT-1:0]  r_reg_valid;
    logic [rvx_pkg::DMEM_WORDS-1:0] r_dmem_valid;
    logic                           r_ld_valid;
    logic [rvx_pkg::XLEN-1:0]       rf_a_rdata;
    logic [rvx_pkg::XLEN-1:0]       rf_b_rdata;
    logic [rvx_pkg::XLEN-1:0]       dmem_rdata;
    logic [rvx_pkg::XLEN-1:0]       s2_value;
    logic [rvx_pkg::XLEN-1:0]       op1;
    logic [rvx_pkg::XLEN-1:0]       op2;
    logic [rvx_pkg::XLEN-1:0]       alu_b;
    logic [rvx_pkg::XLEN-1:0]       alu_y;
    logic [rvx_pkg::XLEN-1:0]       dmem_sum;
    logic [rvx_pkg::DMEM_AW-1:0]    dmem_addr;
    logic [rvx_pkg::PC_W-1:0]       pc_inc;
    logic [rvx_pkg::PC_W-1:0]       pc_jump;
    logic                           rf_we;
    logic                           dmem_we;

    assign advance = !r_out_valid || o_result.ready;
    assign o_pop   = advance && i_head_valid;

    assign rf_we   = advance && r_s2_valid && r_s2.wr;
    assign dmem_we = advance && r_s1_valid && r_s1.kind == rvx_pkg::K_STORE;

    rvx_ram #(.WIDTH(rvx_pkg::XLEN), .DEPTH(rvx_pkg::REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.rd),
        .i_wdata (s2_value),
        .i_re    (advance),
        .i_raddr (i_head.rs1),
        .o_rdata (rf_a_rdata)
    );

    rvx_ram #(.WIDTH(rvx_pkg::XLEN), .DEPTH(rvx_pkg::REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.rd),
        .i_wdata (s2_value),
        .i_re    (advance),
        .i_raddr (i_head.rs2),
        .o_rdata (rf_b_rdata)
    );

    rvx_ram #(.WIDTH(rvx_pkg::XLEN), .DEPTH(rvx_pkg::DMEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dmem_we),
        .i_waddr (dmem_addr),
        .i_wdata (op2),
        .i_re    (advance),
        .i_raddr (dmem_addr),
        .o_rdata (dmem_rdata)
    );

    // Words never stored read as zero.
    assign s2_value = r_s2.is_load ? (r_ld_valid ? dmem_rdata : '0) : r_s2.value;

    // The pending write in the second stage and the one just retired are not yet
    // visible in the register file read data.
    always_comb begin
        priority if (r_s1.rs1 == '0) begin
            op1 = '0;
        end else if (r_s2_valid && r_s2.wr && r_s2.rd == r_s1.rs1) begin
            op1 = s2_value;
        end else if (r_wb_valid && r_wb_rd == r_s1.rs1) begin
            op1 = r_wb_value;
        end else if (r_reg_valid[r_s1.rs1]) begin
            op1 = rf_a_rdata;
        end else begin
            op1 = '0;
        end
    end

    always_comb begin
        priority if (r_s1.rs2 == '0) begin
            op2 = '0;
        end else if (r_s2_valid && r_s2.wr && r_s2.rd == r_s1.rs2) begin
            op2 = s2_value;
        end else if (r_wb_valid && r_wb_rd == r_s1.rs2) begin
            op2 = r_wb_value;
        end else if (r_reg_valid[r_s1.rs2]) begin
            op2 = rf_b_rdata;
        end else begin
            op2 = '0;
        end
    end

    assign alu_b = r_s1.use_imm ? r_s1.imm : op2;

    always_comb begin
        unique case (r_s1.alu_op)
            rvx_pkg::ALU_ADD: alu_y = op1 + alu_b;
            rvx_pkg::ALU_AND: alu_y = op1 & alu_b;
            rvx_pkg::ALU_OR:  alu_y = op1 | alu_b;
            rvx_pkg::ALU_XOR: alu_y = op1 ^ alu_b;
            default:          alu_y = '0;
        endcase
    end

    assign dmem_sum  = op1 + r_s1.imm;
    assign dmem_addr = dmem_sum[rvx_pkg::DMEM_AW-1:0];
    assign pc_inc    = r_pc + 1'b1;
    assign pc_jump   = r_pc + r_s1.imm[rvx_pkg::XLEN-1:2];

    always_comb begin
        exec         = '0;
        exec.next_pc = pc_inc;
        exec.rd      = r_s1.rd;
        unique case (r_s1.kind)
            rvx_pkg::K_ALU: begin
                exec.value = alu_y;
                exec.wr    = 1'b1;
            end
            rvx_pkg::K_LOAD: begin
                exec.is_load = 1'b1;
                exec.wr      = 1'b1;
            end
            rvx_pkg::K_STORE: begin
                exec.store = 1'b1;
            end
            rvx_pkg::K_JAL: begin
                exec.value   = rvx_pkg::XLEN'(pc_inc);
                exec.wr      = 1'b1;
                exec.next_pc = pc_jump;
            end
            rvx_pkg::K_BEQ: begin
                if (op1 == op2) begin
                    exec.next_pc = pc_jump;
                end
            end
            default: begin
                exec.next_pc = r_pc;
                exec.status  = 1'b1;
            end
        endcase
        if (r_s1.rd == '0) begin
            exec.wr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_wb_valid   <= 1'b0;
            r_pc         <= '0;
            r_reg_valid  <= '0;
            r_dmem_valid <= '0;
        end else if (advance) begin
            r_s1_valid  <= i_head_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            r_wb_valid  <= r_s2_valid && r_s2.wr;
            if (r_s1_valid) begin
                r_pc <= exec.next_pc;
            end
            if (rf_we) begin
                r_reg_valid[r_s2.rd] <= 1'b1;
            end
            if (dmem_we) begin
                r_dmem_valid[dmem_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1          <= i_head;
            r_s2          <= exec;
            r_ld_valid    <= r_dmem_valid[dmem_addr];
            r_wb_rd       <= r_s2.rd;
            r_wb_value    <= s2_value;
            r_out.next_pc <= r_s2.next_pc;
            r_out.rd      <= r_s2.wr ? r_s2.rd : '0;
            r_out.value   <= r_s2.wr ? s2_value : '0;
            r_out.wr      <= r_s2.wr;
            r_out.store   <= r_s2.store;
            r_out.status  <= r_s2.status;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.next_pc    = r_out.next_pc;
    assign o_result.dest_index = r_out.rd;
    assign o_result.dest_value = r_out.value;
    assign o_result.dest_write = r_out.wr;
    assign o_result.store_done = r_out.store;
    assign o_result.status     = r_out.status;

endmodule

@@ hw/rtl/rvx_checker.sv @@
// ============================================================================
// RV32I subset execute checker
// Checks the result channel of the execute unit for consistent results.
// ============================================================================
module rvx_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [rvx_pkg::PC_W-1:0]   i_next_pc,
    input logic [rvx_pkg::REG_AW-1:0] i_dest_index,
    input logic [rvx_pkg::XLEN-1:0]   i_dest_value,
    input logic                       i_dest_write,
    input logic                       i_store_done,
    input logic                       i_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_next_pc) && $stable(i_dest_value)
            && $stable(i_dest_index) && $stable(i_status))
        else $error("Result changed while stalled.");

    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> !i_dest_write && !i_store_done)
        else $error("Unsupported instruction wrote state.");

    a_no_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_dest_write |-> i_dest_index == '0 && i_dest_value == '0)
        else $error("Destination fields set without a write.");

    a_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dest_write |-> i_dest_index != '0 && !i_store_done)
        else $error("Register write to x0 or together with a store.");

endmodule

bind rv32i_subset_execute rvx_checker u_rvx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_next_pc    (o_result.next_pc),
    .i_dest_index (o_result.dest_index),
    .i_dest_value (o_result.dest_value),
    .i_dest_write (o_result.dest_write),
    .i_store_done (o_result.store_done),
    .i_status     (o_result.status)
);
